// ===== hw/rtl/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types, codes and sizes for the script line tokenizer.
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int LINE_MAX = 4096;
  localparam int POS_W    = $clog2(LINE_MAX + 1);
  localparam int VAL_W    = 63;
  localparam int START_W  = 12;
  localparam int LEN_W    = 13;
  localparam int RES_MAX  = 3;
  localparam int DATA_W   = 96;

  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(LINE_MAX);
  localparam logic [VAL_W-1:0] VAL_MAX   = {VAL_W{1'b1}};

  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_US    = 8'h5F;
  localparam logic [7:0] CH_ASCII = 8'h7F;

  typedef enum logic [2:0] {
    KIND_NAME   = 3'd0,
    KIND_OP     = 3'd1,
    KIND_INT    = 3'd2,
    KIND_FLOAT  = 3'd3,
    KIND_STRING = 3'd4,
    KIND_ERROR  = 3'd5
  } kind_t;

  typedef enum logic [4:0] {
    OP_ASSIGN = 5'd0,
    OP_ADD    = 5'd1,
    OP_SUB    = 5'd2,
    OP_MUL    = 5'd3,
    OP_DIV    = 5'd4,
    OP_MOD    = 5'd5,
    OP_EQ     = 5'd6,
    OP_NE     = 5'd7,
    OP_LT     = 5'd8,
    OP_GT     = 5'd9,
    OP_LE     = 5'd10,
    OP_GE     = 5'd11,
    OP_NOT    = 5'd12,
    OP_DOT    = 5'd13,
    OP_SEP    = 5'd14,
    OP_LPAREN = 5'd15,
    OP_RPAREN = 5'd16,
    OP_LBRACK = 5'd17,
    OP_RBRACK = 5'd18,
    OP_LBRACE = 5'd19,
    OP_RBRACE = 5'd20
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_NAME   = 2'd1,
    MODE_NUMBER = 2'd2,
    MODE_STRING = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    PEND_NONE   = 3'd0,
    PEND_ASSIGN = 3'd1,
    PEND_LESS   = 3'd2,
    PEND_MORE   = 3'd3,
    PEND_BANG   = 3'd4
  } pend_t;

  typedef struct packed {
    kind_t              kind;
    op_t                op;
    logic [VAL_W-1:0]   value;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } tok_t;

  typedef struct packed {
    logic [1:0]       count;
    tok_t [RES_MAX-1:0] tok;
  } bundle_t;

endpackage

// ===== hw/rtl/slt_scan.sv =====
// ----------------------------------------------------------------------------
// slt_scan
// Input register, line scan state and the per-byte token decision.
// ----------------------------------------------------------------------------
module slt_scan (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,
  input  logic             s_tlast,
  input  logic             free,
  output logic             load,
  output slt_pkg::bundle_t bundle
);
  import slt_pkg::*;

  logic             in_valid;
  logic [7:0]       in_char;
  logic             in_eol;

  logic [POS_W-1:0] pos;
  mode_t            mode;
  logic [POS_W-1:0] start;
  pend_t            pend;
  logic [VAL_W-1:0] acc;
  logic             flt;
  logic             skip;

  logic [POS_W-1:0] pos_next;
  mode_t            mode_next;
  logic [POS_W-1:0] start_next;
  pend_t            pend_next;
  logic [VAL_W-1:0] acc_next;
  logic             flt_next;
  logic             skip_next;

  logic [POS_W-1:0] pos_mid;
  mode_t            mode_mid;
  logic [POS_W-1:0] start_mid;
  pend_t            pend_mid;
  logic [VAL_W-1:0] acc_mid;
  logic             flt_mid;
  logic             skip_mid;

  logic             act, p_path, p_dbl, p_single, m_path;
  logic             name_end, name_err, name_ok;
  logic             num_digit, num_dot, num_err, num_end;
  logic             str_close, run_idle;
  logic             c_letter, c_digit, c_quote, c_pend;
  logic             c_single;
  op_t              c_op;
  logic [VAL_W+3:0] acc_x10;
  logic [VAL_W-1:0] acc_step;

  tok_t             e1, e2, e3;
  logic             e1_v, e2_v, e3_v;
  logic [1:0]       n;

  function automatic op_t pend_single(input pend_t p);
    op_t r;
    case (p)
      PEND_ASSIGN: r = OP_ASSIGN;
      PEND_LESS:   r = OP_LT;
      PEND_MORE:   r = OP_GT;
      default:     r = OP_NOT;
    endcase
    return r;
  endfunction

  function automatic op_t pend_double(input pend_t p);
    op_t r;
    case (p)
      PEND_ASSIGN: r = OP_EQ;
      PEND_LESS:   r = OP_LE;
      PEND_MORE:   r = OP_GE;
      default:     r = OP_NE;
    endcase
    return r;
  endfunction

  function automatic tok_t make_tok(input kind_t k, input op_t o, input logic [VAL_W-1:0] v,
                                    input logic [POS_W-1:0] s, input logic [POS_W-1:0] l);
    tok_t t;
    t.kind  = k;
    t.op    = o;
    t.value = v;
    t.start = START_W'(s);
    t.len   = LEN_W'(l);
    return t;
  endfunction

  assign load     = in_valid && free;
  assign s_tready = !in_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (load) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_eol  <= s_tlast;
    end
  end

  // Character classes and path decode
  always_comb begin
    c_letter = in_char inside {[8'h41:8'h5A], [8'h61:8'h7A], CH_US};
    c_digit  = in_char inside {[8'h30:8'h39]};
    c_quote  = in_char == CH_QUOTE;
    c_pend   = in_char inside {CH_EQ, CH_LT, CH_GT, CH_BANG};
    c_single = 1'b1;
    case (in_char)
      8'h2B:   c_op = OP_ADD;
      8'h2D:   c_op = OP_SUB;
      8'h2A:   c_op = OP_MUL;
      8'h2F:   c_op = OP_DIV;
      8'h25:   c_op = OP_MOD;
      CH_DOT:  c_op = OP_DOT;
      8'h2C:   c_op = OP_SEP;
      8'h28:   c_op = OP_LPAREN;
      8'h29:   c_op = OP_RPAREN;
      8'h5B:   c_op = OP_LBRACK;
      8'h5D:   c_op = OP_RBRACK;
      8'h7B:   c_op = OP_LBRACE;
      8'h7D:   c_op = OP_RBRACE;
      default: begin
        c_op     = OP_ASSIGN;
        c_single = 1'b0;
      end
    endcase

    act       = (pos < POS_LIMIT) && !skip;
    p_path    = act && (pend != PEND_NONE);
    p_dbl     = p_path && (in_char == CH_EQ);
    p_single  = p_path && !p_dbl;
    m_path    = act && (pend == PEND_NONE);
    name_end  = m_path && (mode == MODE_NAME) && !(c_letter || c_digit);
    name_err  = name_end && (in_char > CH_ASCII);
    name_ok   = name_end && !name_err;
    num_digit = m_path && (mode == MODE_NUMBER) && c_digit;
    num_dot   = m_path && (mode == MODE_NUMBER) && (in_char == CH_DOT);
    num_err   = num_dot && flt;
    num_end   = m_path && (mode == MODE_NUMBER) && !c_digit && !num_dot;
    str_close = m_path && (mode == MODE_STRING) && c_quote;
    run_idle  = p_single || name_ok || num_end || (m_path && (mode == MODE_IDLE));

    acc_x10  = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{VAL_W{1'b0}}, in_char[3:0]};
    acc_step = (acc_x10 > {4'b0, VAL_MAX}) ? VAL_MAX : acc_x10[VAL_W-1:0];
  end

  // Next state
  always_comb begin
    pos_mid   = (pos < POS_LIMIT) ? pos + 1'b1 : pos;
    mode_mid  = mode;
    start_mid = start;
    pend_mid  = pend;
    acc_mid   = acc;
    flt_mid   = flt;
    skip_mid  = skip || name_err || num_err;

    if (p_path) begin
      pend_mid = PEND_NONE;
    end
    if (name_err || num_err || str_close || name_ok || num_end) begin
      mode_mid = MODE_IDLE;
    end
    if (num_digit && !flt) begin
      acc_mid = acc_step;
    end
    if (num_dot && !flt) begin
      flt_mid = 1'b1;
    end
    if (run_idle) begin
      if (c_letter || c_quote || c_digit || c_pend) begin
        start_mid = pos;
      end
      if (c_letter) begin
        mode_mid = MODE_NAME;
      end else if (c_quote) begin
        mode_mid = MODE_STRING;
      end else if (c_digit) begin
        mode_mid = MODE_NUMBER;
        acc_mid  = {{(VAL_W-4){1'b0}}, in_char[3:0]};
        flt_mid  = 1'b0;
      end else if (in_char == CH_EQ) begin
        pend_mid = PEND_ASSIGN;
      end else if (in_char == CH_LT) begin
        pend_mid = PEND_LESS;
      end else if (in_char == CH_GT) begin
        pend_mid = PEND_MORE;
      end else if (in_char == CH_BANG) begin
        pend_mid = PEND_BANG;
      end
    end

    if (in_eol) begin
      pos_next   = '0;
      mode_next  = MODE_IDLE;
      start_next = '0;
      pend_next  = PEND_NONE;
      acc_next   = '0;
      flt_next   = 1'b0;
      skip_next  = 1'b0;
    end else begin
      pos_next   = pos_mid;
      mode_next  = mode_mid;
      start_next = start_mid;
      pend_next  = pend_mid;
      acc_next   = acc_mid;
      flt_next   = flt_mid;
      skip_next  = skip_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      mode  <= MODE_IDLE;
      start <= '0;
      pend  <= PEND_NONE;
      acc   <= '0;
      flt   <= 1'b0;
      skip  <= 1'b0;
    end else if (load) begin
      pos   <= pos_next;
      mode  <= mode_next;
      start <= start_next;
      pend  <= pend_next;
      acc   <= acc_next;
      flt   <= flt_next;
      skip  <= skip_next;
    end
  end

  // Token outputs
  always_comb begin
    e1_v = 1'b1;
    if (p_dbl) begin
      e1 = make_tok(KIND_OP, pend_double(pend), '0, start, POS_W'(2));
    end else if (p_single) begin
      e1 = make_tok(KIND_OP, pend_single(pend), '0, start, POS_W'(1));
    end else if (name_err || num_err) begin
      e1 = make_tok(KIND_ERROR, OP_ASSIGN, '0, start, pos + 1'b1 - start);
    end else if (name_ok) begin
      e1 = make_tok(KIND_NAME, OP_ASSIGN, '0, start, pos - start);
    end else if (num_end && flt) begin
      e1 = make_tok(KIND_FLOAT, OP_ASSIGN, '0, start, pos - start);
    end else if (num_end) begin
      e1 = make_tok(KIND_INT, OP_ASSIGN, acc, start, pos - start);
    end else if (str_close) begin
      e1 = make_tok(KIND_STRING, OP_ASSIGN, '0, start, pos - start - 1'b1);
    end else begin
      e1   = '0;
      e1_v = 1'b0;
    end

    e2_v = run_idle && c_single;
    e2   = make_tok(KIND_OP, c_op, '0, pos, POS_W'(1));

    e3_v = in_eol && !skip_mid;
    if (pend_mid != PEND_NONE) begin
      e3 = make_tok(KIND_OP, pend_single(pend_mid), '0, start_mid, POS_W'(1));
    end else if (mode_mid == MODE_NAME) begin
      e3 = make_tok(KIND_NAME, OP_ASSIGN, '0, start_mid, pos_mid - start_mid);
    end else if (mode_mid == MODE_NUMBER && flt_mid) begin
      e3 = make_tok(KIND_FLOAT, OP_ASSIGN, '0, start_mid, pos_mid - start_mid);
    end else if (mode_mid == MODE_NUMBER) begin
      e3 = make_tok(KIND_INT, OP_ASSIGN, acc_mid, start_mid, pos_mid - start_mid);
    end else if (mode_mid == MODE_STRING) begin
      e3 = make_tok(KIND_ERROR, OP_ASSIGN, '0, start_mid, pos_mid - start_mid);
    end else begin
      e3   = '0;
      e3_v = 1'b0;
    end

    n          = 2'd0;
    bundle.tok = '0;
    if (e1_v) begin
      bundle.tok[n] = e1;
      n             = n + 2'd1;
    end
    if (e2_v) begin
      bundle.tok[n] = e2;
      n             = n + 2'd1;
    end
    if (e3_v) begin
      bundle.tok[n] = e3;
      n             = n + 2'd1;
    end
    bundle.count = n;
  end

endmodule

// ===== hw/rtl/slt_outq.sv =====
// ----------------------------------------------------------------------------
// slt_outq
// Result register: holds the tokens of one byte and hands them out in order.
// ----------------------------------------------------------------------------
module slt_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  slt_pkg::bundle_t bundle,
  output logic             free,
  output logic             m_tvalid,
  input  logic             m_tready,
  output slt_pkg::tok_t    head,
  output logic             m_tlast
);
  import slt_pkg::*;

  tok_t [RES_MAX-1:0] slot;
  logic [1:0]         cnt;

  assign m_tvalid = cnt != 2'd0;
  assign m_tlast  = cnt == 2'd1;
  assign head     = slot[0];
  assign free     = (cnt == 2'd0) || ((cnt == 2'd1) && m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= bundle.count;
    end else if (m_tvalid && m_tready) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= bundle.tok;
    end else if (m_tvalid && m_tready) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

endmodule

// ===== hw/rtl/script_line_tokenizer.sv =====
// ----------------------------------------------------------------------------
// script_line_tokenizer
// Splits a script line, one byte per transfer, into name, operator, number
// and string tokens with their start offsets and lengths.
//
//   channel | dir | tdata                      | tuser      | tlast
//   s_*     | in  | char_code                  | -          | end_of_line
//   m_*     | out | op, value, start, length   | token_kind | last_of_run
//
// One byte is taken per cycle while the result register is free; each byte
// gives zero to two tokens, and the result register sends one token per
// cycle while m_tready is high, so a byte with several tokens holds the input
// until its last token is taken. A byte passes the input register and then
// the result register. Reset is synchronous and starts a fresh line. The input
// register holds one byte while a token waits for m_tready; then the input stalls.
// ----------------------------------------------------------------------------
module script_line_tokenizer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [7:0] char_code
  input  logic                       s_tlast,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [slt_pkg::DATA_W-1:0] m_tdata,   // [4:0] operator_code, [67:5] integer_value,
                                                // [79:68] token_start, [92:80] token_length
  output logic [2:0]                 m_tuser,   // [2:0] token_kind
  output logic                       m_tlast
);
  import slt_pkg::*;

  logic    free;
  logic    load;
  bundle_t bundle;
  tok_t    head;

  slt_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .free     (free),
    .load     (load),
    .bundle   (bundle)
  );

  slt_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .bundle   (bundle),
    .free     (free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head     (head),
    .m_tlast  (m_tlast)
  );

  assign m_tuser = head.kind;
  assign m_tdata = {3'b0, head.len, head.start, head.value, head.op};

endmodule

// ===== hw/rtl/slt_check.sv =====
// ----------------------------------------------------------------------------
// slt_check
// Port-level checks for the script line tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module slt_check (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [slt_pkg::DATA_W-1:0] m_tdata,
  input logic [2:0]                 m_tuser,
  input logic                       m_tlast
);
  import slt_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("token changed while stalled");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input held off with no token waiting");

  a_op_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != KIND_OP) |-> m_tdata[4:0] == 5'd0)
    else $error("operator code set on a non-operator token");

  a_val_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != KIND_INT) |-> m_tdata[67:5] == '0)
    else $error("value set on a non-integer token");

  a_op_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_OP) |-> (m_tdata[92:80] == 13'd1) || (m_tdata[92:80] == 13'd2))
    else $error("operator token with bad length");

endmodule

bind script_line_tokenizer slt_check u_check (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
